[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros: assertion wrappers
// Clocked property checks with and without a reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

[src/hmoa_pkg.sv]
// ---------------------------------------------------------------------------
// hmoa_pkg: shared types and constants
// Status codes, commands, engine states and beat payloads for the hash table.
// ---------------------------------------------------------------------------
package hmoa_pkg;
   localparam int CAPACITY_DEF = 256;
   localparam int SIZE_W       = 9;

   typedef enum logic [2:0] {
      ST_NEW   = 3'd0,
      ST_ACC   = 3'd1,
      ST_FOUND = 3'd2,
      ST_MISS  = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic REG_PROBING = 1'b0;
   localparam logic REG_SIZE    = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_READ, S_CHECK, S_OUT
   } state_type;

   typedef struct packed {
      logic        command;
      logic [31:0] key;
      logic [31:0] hash_value;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value_out;
      logic [7:0]  slot_index;
   } rsp_type;
endpackage

[src/hmoa_if.sv]
// ---------------------------------------------------------------------------
// hmoa_if: valid/ready channel
// Carries one beat of a struct payload.
// ---------------------------------------------------------------------------
interface hmoa_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[src/hmoa_mod.sv]
// ---------------------------------------------------------------------------
// hmoa_mod: serial modulo unit
// Restoring reduction of a 32-bit hash by the table size, one bit a cycle.
// ---------------------------------------------------------------------------
module hmoa_mod #(
   parameter int IDX_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        dividend,
   input  logic [IDX_W:0]     divisor,
   output logic               done,
   output logic [IDX_W-1:0]   remainder
);
   logic [31:0]    shift_ff, shift_in;
   logic [IDX_W:0] rem_ff, rem_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [IDX_W+1:0] trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff, shift_ff[31]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = 6'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[30:0], 1'b0};
         if (trial >= {1'b0, divisor}) trial = trial - {1'b0, divisor};
         rem_in = trial[IDX_W:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == 6'd31);
   assign remainder = rem_in[IDX_W-1:0];
endmodule

[src/hmoa_store.sv]
// ---------------------------------------------------------------------------
// hmoa_store: slot memories
// Key and value RAMs with registered reads; occupied bits in flops.
// ---------------------------------------------------------------------------
module hmoa_store #(
   parameter int CAPACITY = 256,
   parameter int IDX_W    = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [31:0]      rd_key,
   output logic [31:0]      rd_value,
   output logic             rd_occ,
   input  logic             wr_en,
   input  logic             wr_key_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [31:0]      wr_key,
   input  logic [31:0]      wr_value
);
   logic [31:0]         key_mem [CAPACITY];
   logic [31:0]         val_mem [CAPACITY];
   logic [CAPACITY-1:0] occ_ff;
   logic [31:0]         rd_key_ff, rd_value_ff;
   logic                rd_occ_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_mem[wr_addr] <= wr_value;
         if (wr_key_en) key_mem[wr_addr] <= wr_key;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         rd_occ_ff <= 1'b0;
      end else begin
         if (wr_en) occ_ff[wr_addr] <= 1'b1;
         rd_occ_ff <= occ_ff[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;
   assign rd_occ   = rd_occ_ff;
endmodule

[src/hash_map_open_addressing_accumulate.sv]
// ---------------------------------------------------------------------------
// hash_map_open_addressing_accumulate: open-addressing table with accumulate
// Insert-or-add and lookup over key/value RAMs, linear or quadratic probing.
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// req      in   req_valid/ready    command, key, hash_value, value
// rsp      out  rsp_valid/ready    status, value_out, slot_index
// csr      in   csr_write_enable   csr_index, csr_write_data
//
// One beat at a time: the hash is reduced by the serial modulo, then each probe
// does a RAM read, then a compare, and the result is then presented.
// Probe count is 1..size, set by load and probe mode.
// Synchronous reset clears occupied bits and count, and resets state and settings at once.
// The result beat sits in an output register until taken; req is held off.
`include "assert_macros.svh"
module hash_map_open_addressing_accumulate #(
   parameter int CAPACITY = hmoa_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   hmoa_if.sink                      req,
   hmoa_if.source                    rsp,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [hmoa_pkg::SIZE_W-1:0] csr_write_data
);
   localparam int IDX_W = $clog2(CAPACITY);

   hmoa_pkg::state_type state_ff, state_in;
   hmoa_pkg::req_type   item_ff, item_in;
   hmoa_pkg::rsp_type   out_ff, out_in;

   logic                    mode_ff;
   logic [hmoa_pkg::SIZE_W-1:0] tsize_ff;
   logic [8:0]              count_ff, count_in;
   logic [IDX_W:0]          size;       // effective size 1..CAPACITY
   logic [IDX_W-1:0]        start_ff, start_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;   // current probe slot
   logic [IDX_W:0]          step_ff, step_in;   // probe number i
   logic [IDX_W:0]          inc;                // added to reach next slot
   logic [IDX_W+1:0]        nxt;

   logic                    mod_start, mod_done;
   logic [IDX_W-1:0]        mod_rem;
   logic [31:0]             rd_key, rd_value;
   logic                    rd_occ;
   logic                    wr_en, wr_key_en;
   logic [31:0]             wr_value;

   // size clamp: 0 acts as 1, above capacity acts as capacity
   always_comb begin
      if (tsize_ff == '0) size = (IDX_W+1)'(1);
      else if (32'(tsize_ff) > 32'(CAPACITY)) size = (IDX_W+1)'(CAPACITY);
      else size = (IDX_W+1)'(tsize_ff);
   end

   hmoa_mod #(.IDX_W(IDX_W)) u_mod (
      .clock, .reset, .start(mod_start), .dividend(item_ff.hash_value),
      .divisor(size), .done(mod_done), .remainder(mod_rem)
   );

   hmoa_store #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_store (
      .clock, .reset, .rd_addr(slot_ff), .rd_key, .rd_value, .rd_occ,
      .wr_en, .wr_key_en, .wr_addr(slot_ff), .wr_key(item_ff.key),
      .wr_value
   );

   // quadratic: (i+1)^2 - i^2 = 2i+1, reduced mod size incrementally
   always_comb begin
      inc = mode_ff ? {step_ff[IDX_W-1:0], 1'b1} : (IDX_W+1)'(1);
      if (inc >= size) inc = inc - size;
      if (inc >= size) inc = inc - size;
      nxt = {1'b0, slot_ff} + {1'b0, inc};
      if (nxt >= {1'b0, size}) nxt = nxt - {1'b0, size};
   end

   assign req.ready = (state_ff == hmoa_pkg::S_IDLE);
   assign rsp.valid = (state_ff == hmoa_pkg::S_OUT);
   assign rsp.data  = out_ff;

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      out_in    = out_ff;
      start_in  = start_ff;
      slot_in   = slot_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      mod_start = 1'b0;
      wr_en     = 1'b0;
      wr_key_en = 1'b0;
      wr_value  = item_ff.value;
      unique case (state_ff)
         hmoa_pkg::S_IDLE: begin
            if (req.valid) begin
               item_in   = req.data;
               state_in  = hmoa_pkg::S_MOD;
            end
         end
         hmoa_pkg::S_MOD: begin
            if (!mod_done) mod_start = (step_ff == '1);
            if (mod_done) begin
               start_in = mod_rem;
               slot_in  = mod_rem;
               step_in  = '0;
               state_in = hmoa_pkg::S_READ;
            end
         end
         hmoa_pkg::S_READ: state_in = hmoa_pkg::S_CHECK;
         hmoa_pkg::S_CHECK: begin
            if (!rd_occ) begin
               if (item_ff.command == hmoa_pkg::CMD_INSERT) begin
                  wr_en     = 1'b1;
                  wr_key_en = 1'b1;
                  count_in  = count_ff + 9'd1;
                  out_in    = '{hmoa_pkg::ST_NEW, item_ff.value, 8'(slot_ff)};
               end else begin
                  out_in = '{hmoa_pkg::ST_MISS, 32'd0, 8'd0};
               end
               state_in = hmoa_pkg::S_OUT;
            end else if (rd_key == item_ff.key) begin
               if (item_ff.command == hmoa_pkg::CMD_INSERT) begin
                  wr_value = rd_value + item_ff.value;
                  wr_en    = 1'b1;
                  out_in   = '{hmoa_pkg::ST_ACC, wr_value, 8'(slot_ff)};
               end else begin
                  out_in = '{hmoa_pkg::ST_FOUND, rd_value, 8'(slot_ff)};
               end
               state_in = hmoa_pkg::S_OUT;
            end else if (step_ff + (IDX_W+1)'(1) >= size) begin
               out_in = (item_ff.command == hmoa_pkg::CMD_INSERT)
                      ? hmoa_pkg::rsp_type'{hmoa_pkg::ST_FULL, 32'd0, 8'd0}
                      : hmoa_pkg::rsp_type'{hmoa_pkg::ST_MISS, 32'd0, 8'd0};
               state_in = hmoa_pkg::S_OUT;
            end else begin
               step_in  = step_ff + (IDX_W+1)'(1);
               slot_in  = nxt[IDX_W-1:0];
               state_in = hmoa_pkg::S_READ;
            end
         end
         hmoa_pkg::S_OUT: begin
            if (rsp.ready) begin
               state_in = hmoa_pkg::S_IDLE;
               step_in  = '1;
            end
         end
         default: state_in = hmoa_pkg::S_IDLE;
      endcase
   end

   // step_ff is all ones on entry to S_MOD, which launches the modulo once
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmoa_pkg::S_IDLE;
         count_ff <= '0;
         mode_ff  <= 1'b0;
         tsize_ff <= hmoa_pkg::SIZE_W'(256);
         step_ff  <= '1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= (state_ff == hmoa_pkg::S_MOD && step_ff == '1 && !mod_done)
                   ? '0 : step_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               hmoa_pkg::REG_PROBING: mode_ff  <= csr_write_data[0];
               hmoa_pkg::REG_SIZE:    tsize_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      item_ff  <= item_in;
      out_ff   <= out_in;
      start_ff <= start_in;
      slot_ff  <= slot_in;
   end

   // start slot always lies inside the table in use
   `ASSERT_IMPL(a_start_in_range, clock, reset, (state_ff == hmoa_pkg::S_READ) |-> ({1'b0, start_ff} < size))
   // probe slot never leaves the table in use
   `ASSERT_IMPL(a_slot_in_range, clock, reset, (state_ff == hmoa_pkg::S_CHECK) |-> ({1'b0, slot_ff} < size))
   // a held result does not change while stalled
   `ASSERT_IMPL(a_rsp_hold, clock, reset, (rsp.valid && !rsp.ready) |=> $stable(out_ff))
endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for hash_map_open_addressing_accumulate
// Drives insert/lookup beats through the req channel and checks every rsp beat
// against a scoreboard fed by a behavioural copy of the table, over several
// size and probing settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 256;
   localparam int IDLE_LIMIT  = 4000;   // one worst-case probe walk plus a long stall
   localparam int DRAIN_WAIT  = 4;
   localparam int PHASE_BEATS = 95;
   localparam int KEY_POOL    = 48;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 command;
      logic [31:0]          key;
      logic [31:0]          hash_value;
      logic [31:0]          value;
      logic                 typed;        // expectation written out below
      hmoa_pkg::status_type want_status;
      logic [31:0]          want_value;
      logic [7:0]           want_slot;
      logic                 csr_sel;
      logic [8:0]           csr_data;
   } row_type;

   // note carried alongside each offered beat, popped when it is accepted
   typedef struct packed {
      logic              typed;
      hmoa_pkg::rsp_type want;
   } beat_note_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = hmoa_pkg::REG_PROBING;
   logic [8:0] csr_write_data = '0;

   hmoa_if #(.payload_type(hmoa_pkg::req_type)) req_ch ();
   hmoa_if #(.payload_type(hmoa_pkg::rsp_type)) rsp_ch ();

   hash_map_open_addressing_accumulate u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---- table model -------------------------------------------------------
   logic [31:0] tbl_key   [SLOTS];
   logic [31:0] tbl_value [SLOTS];
   bit          tbl_used  [SLOTS];
   logic        cfg_quadratic = 1'b0;
   logic [8:0]  cfg_size = 9'd256;

   hmoa_pkg::rsp_type rsp_expected [$];
   beat_note_type     beat_notes   [$];
   int                fail_count = 0;
   int                idle_cycles = 0;
   int                rsp_beats = 0;

   // Walks the probe path exactly as the block must, updating the model.
   function automatic hmoa_pkg::rsp_type probe_and_update(hmoa_pkg::req_type r);
      hmoa_pkg::rsp_type res;
      int unsigned       sz;
      int unsigned       first;
      int unsigned       idx;
      sz = cfg_size;
      if (sz == 0) sz = 1;            // size 0 behaves as 1
      if (sz > SLOTS) sz = SLOTS;     // oversize clamps to capacity
      first = r.hash_value % sz;
      res.status     = (r.command == hmoa_pkg::CMD_INSERT) ? hmoa_pkg::ST_FULL
                                                           : hmoa_pkg::ST_MISS;
      res.value_out  = '0;
      res.slot_index = '0;
      for (int unsigned i = 0; i < sz; i++) begin
         idx = (first + (cfg_quadratic ? i * i : i)) % sz;
         if (!tbl_used[idx]) begin
            if (r.command == hmoa_pkg::CMD_INSERT) begin
               tbl_used[idx]  = 1'b1;
               tbl_key[idx]   = r.key;
               tbl_value[idx] = r.value;
               res.status     = hmoa_pkg::ST_NEW;
               res.value_out  = r.value;
               res.slot_index = idx[7:0];
            end
            break;
         end
         if (tbl_key[idx] == r.key) begin
            if (r.command == hmoa_pkg::CMD_INSERT) begin
               tbl_value[idx] = tbl_value[idx] + r.value;
               res.status = hmoa_pkg::ST_ACC;
            end else begin
               res.status = hmoa_pkg::ST_FOUND;
            end
            res.value_out  = tbl_value[idx];
            res.slot_index = idx[7:0];
            break;
         end
      end
      return res;
   endfunction

   // ---- accepted req beats: predict; accepted rsp beats: compare -----------
   always @(posedge clock) begin
      beat_note_type     note;
      hmoa_pkg::rsp_type pred;
      hmoa_pkg::rsp_type want;
      if (!reset && req_ch.valid && req_ch.ready) begin
         note = beat_notes.pop_front();
         pred = probe_and_update(req_ch.data);
         if (note.typed) pred = note.want;
         rsp_expected.insert(rsp_expected.size(), pred);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_beats++;
         if (rsp_expected.size() == 0) begin
            $error("rsp beat with nothing expected");
            fail_count++;
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_ch.data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.data.status);
               fail_count++;
            end
            if (rsp_ch.data.value_out !== want.value_out) begin
               $error("value_out: expected %h, got %h", want.value_out,
                      rsp_ch.data.value_out);
               fail_count++;
            end
            if (rsp_ch.data.slot_index !== want.slot_index) begin
               $error("slot_index: expected %0d, got %0d", want.slot_index,
                      rsp_ch.data.slot_index);
               fail_count++;
            end
         end
      end
   end

   // ---- watchdog: cycles with no beat on either channel --------------------
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("hash_map_open_addressing_accumulate test failed");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---- rsp side: random stalls, one long hold-off to back up req ---------
   int  stall_left = 0;
   bit  long_hold_done = 1'b0;
   bit  rsp_steady = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (!long_hold_done && rsp_beats >= 300) begin
               long_hold_done = 1'b1;
               stall_left <= 400;
            end else begin
               // alternate stretches of no stalling with choppy stretches
               if ($urandom_range(0, 49) == 0) rsp_steady = !rsp_steady;
               stall_left <= rsp_steady ? 0 : pick_gap();
            end
         end
      end
   end

   // ---- req side ----------------------------------------------------------
   task automatic drain();
      while (rsp_expected.size() != 0 || beat_notes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic sel, logic [8:0] data);
      req_ch.valid <= 1'b0;
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (sel == hmoa_pkg::REG_PROBING) cfg_quadratic = data[0];
      else                              cfg_size      = data;
   endtask

   // offers one beat and returns at the edge it is taken; valid stays high
   task automatic send_beat(hmoa_pkg::req_type r, beat_note_type note);
      beat_notes.insert(beat_notes.size(), note);
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic gap_after_beat(bit steady);
      int g;
      g = steady ? 0 : pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // directed rows: reset contents, extremes, collisions, full and size cases
   row_type dir_rows [19] = '{
      '{ROW_ITEM, hmoa_pkg::CMD_LOOKUP, 32'h0, 32'h0, 32'h0,
        1'b1, hmoa_pkg::ST_MISS, 32'h0, 8'd0, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_INSERT, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF,
        1'b1, hmoa_pkg::ST_NEW, 32'h7FFFFFFF, 8'd255, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_INSERT, 32'h80000000, 32'hFFFFFFFF, 32'h1,
        1'b1, hmoa_pkg::ST_ACC, 32'h80000000, 8'd255, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_LOOKUP, 32'h80000000, 32'hFFFFFFFF, 32'h0,
        1'b1, hmoa_pkg::ST_FOUND, 32'h80000000, 8'd255, 1'b0, 9'd0},
      // collision at the top slot wraps round to slot 0
      '{ROW_ITEM, hmoa_pkg::CMD_INSERT, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000,
        1'b1, hmoa_pkg::ST_NEW, 32'h80000000, 8'd0, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_LOOKUP, 32'h7FFFFFFF, 32'h000000FF, 32'h0,
        1'b1, hmoa_pkg::ST_FOUND, 32'h80000000, 8'd0, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_INSERT, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF,
        1'b1, hmoa_pkg::ST_NEW, 32'hFFFFFFFF, 8'd1, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_LOOKUP, 32'h5, 32'h0, 32'h0,
        1'b1, hmoa_pkg::ST_MISS, 32'h0, 8'd0, 1'b0, 9'd0},
      // shrink to one slot while filled: full insert, lookup with no empty slot
      '{ROW_CSR, hmoa_pkg::CMD_INSERT, 32'h0, 32'h0, 32'h0,
        1'b0, hmoa_pkg::ST_NEW, 32'h0, 8'd0, hmoa_pkg::REG_SIZE, 9'd1},
      '{ROW_ITEM, hmoa_pkg::CMD_INSERT, 32'h0, 32'd77, 32'h0,
        1'b1, hmoa_pkg::ST_FULL, 32'h0, 8'd0, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_LOOKUP, 32'h9, 32'h0, 32'h0,
        1'b1, hmoa_pkg::ST_MISS, 32'h0, 8'd0, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_INSERT, 32'h7FFFFFFF, 32'h3, 32'h5,
        1'b1, hmoa_pkg::ST_ACC, 32'h80000005, 8'd0, 1'b0, 9'd0},
      // size 0 behaves as one slot
      '{ROW_CSR, hmoa_pkg::CMD_INSERT, 32'h0, 32'h0, 32'h0,
        1'b0, hmoa_pkg::ST_NEW, 32'h0, 8'd0, hmoa_pkg::REG_SIZE, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_LOOKUP, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0,
        1'b1, hmoa_pkg::ST_FOUND, 32'h80000005, 8'd0, 1'b0, 9'd0},
      // quadratic, oversize clamps to capacity
      '{ROW_CSR, hmoa_pkg::CMD_INSERT, 32'h0, 32'h0, 32'h0,
        1'b0, hmoa_pkg::ST_NEW, 32'h0, 8'd0, hmoa_pkg::REG_PROBING, 9'd1},
      '{ROW_CSR, hmoa_pkg::CMD_INSERT, 32'h0, 32'h0, 32'h0,
        1'b0, hmoa_pkg::ST_NEW, 32'h0, 8'd0, hmoa_pkg::REG_SIZE, 9'd511},
      '{ROW_ITEM, hmoa_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'h0,
        1'b1, hmoa_pkg::ST_FOUND, 32'hFFFFFFFF, 8'd1, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_INSERT, 32'h12345678, 32'h0, 32'h0,
        1'b1, hmoa_pkg::ST_NEW, 32'h0, 8'd4, 1'b0, 9'd0},
      '{ROW_ITEM, hmoa_pkg::CMD_INSERT, 32'h12345678, 32'h0, 32'hFFFFFFFF,
        1'b0, hmoa_pkg::ST_NEW, 32'h0, 8'd0, 1'b0, 9'd0}
   };

   // random phases: {quadratic, size written}
   logic [9:0] phase_cfg [8] = '{
      {1'b0, 9'd256}, {1'b1, 9'd16}, {1'b0, 9'd1}, {1'b1, 9'd0},
      {1'b0, 9'd511}, {1'b1, 9'd256}, {1'b0, 9'd5}, {1'b1, 9'd13}
   };

   logic [31:0] pool_key  [KEY_POOL];
   logic [31:0] pool_hash [KEY_POOL];

   initial begin
      hmoa_pkg::req_type r;
      beat_note_type     note;
      int                k;
      bit                steady;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      foreach (pool_key[i]) begin
         pool_key[i]  = $urandom();
         pool_hash[i] = $urandom();
      end
      pool_key[0] = 32'h0;
      pool_key[1] = 32'hFFFFFFFF;
      pool_key[2] = 32'h80000000;
      pool_key[3] = 32'h7FFFFFFF;
      pool_hash[1] = 32'hFFFFFFFF;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            write_reg(dir_rows[i].csr_sel, dir_rows[i].csr_data);
         end else begin
            r = '{dir_rows[i].command, dir_rows[i].key, dir_rows[i].hash_value,
                  dir_rows[i].value};
            note.typed = dir_rows[i].typed;
            note.want  = '{dir_rows[i].want_status, dir_rows[i].want_value,
                           dir_rows[i].want_slot};
            send_beat(r, note);
            gap_after_beat(1'b0);
         end
      end

      // random part: each phase starts from an idle block with new settings
      steady = 1'b0;
      foreach (phase_cfg[p]) begin
         write_reg(hmoa_pkg::REG_PROBING, {8'd0, phase_cfg[p][9]});
         write_reg(hmoa_pkg::REG_SIZE, phase_cfg[p][8:0]);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            k = $urandom_range(0, KEY_POOL - 1);
            r.command = 1'($urandom_range(0, 1));
            r.key     = ($urandom_range(0, 4) == 0) ? $urandom() : pool_key[k];
            r.hash_value = ($urandom_range(0, 4) == 0) ? $urandom() : pool_hash[k];
            r.value   = $urandom();
            note = '0;
            send_beat(r, note);
            if ($urandom_range(0, 29) == 0) steady = !steady;
            if ($urandom_range(0, 39) == 0) begin
               req_ch.valid <= 1'b0;   // pause until everything is back
               drain();
            end else begin
               gap_after_beat(steady);
            end
         end
      end

      req_ch.valid <= 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && rsp_expected.size() == 0)
         $display("hash_map_open_addressing_accumulate test passed");
      else
         $display("hash_map_open_addressing_accumulate test failed");
      $finish;
   end
endmodule
